FILE: sv/i2b_pkg.sv
// Shared constants and types of the base-100 NUMBER encoder.
// Used by i2b_cell, int64_to_base100_number and i2b_checker; depends on nothing.
`default_nettype none

package i2b_pkg;

  localparam int unsigned ValueW    = 64;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned DigitW    = 7;
  localparam int unsigned DigitsMax = 10;
  localparam int unsigned StepBits  = 2;
  localparam int unsigned Steps     = ValueW / StepBits;
  localparam int unsigned ConvLast  = Steps + DigitsMax - 2;
  localparam int unsigned CntW      = $clog2(ConvLast + 1);
  localparam int unsigned IdxW      = $clog2(DigitsMax);
  localparam int unsigned CellSumW  = DigitW + StepBits;

  localparam logic [CellSumW-1:0] Radix  = CellSumW'(100);
  localparam logic [CellSumW-1:0] Radix2 = CellSumW'(200);
  localparam logic [CellSumW-1:0] Radix3 = CellSumW'(300);

  localparam logic [ByteW-1:0] ZeroByte    = 8'h80;
  localparam logic [ByteW-1:0] ExpFlag     = 8'h80;
  localparam logic [ByteW-1:0] ExpBias     = 8'd65;
  localparam logic [ByteW-1:0] NegDigitTop = 8'd101;
  localparam logic [ByteW-1:0] TermByte    = 8'h66;

  typedef struct packed {
    logic                vld;
    logic [StepBits-1:0] carry;
  } link_t;

endpackage

`default_nettype wire

FILE: sv/i2b_cell.sv
// One base-100 digit cell of the binary-to-base-100 conversion chain.
// Depends on i2b_pkg for widths and the link type.
`default_nettype none

module i2b_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       clr_i,
  input  wire i2b_pkg::link_t             link_i,
  output i2b_pkg::link_t                  link_o,
  output logic [i2b_pkg::DigitW-1:0]      digit_o
);

  logic [i2b_pkg::DigitW-1:0]   digit_q, digit_d;
  i2b_pkg::link_t               link_q, link_d;
  logic [i2b_pkg::CellSumW-1:0] sum;
  logic [i2b_pkg::CellSumW-1:0] rem;
  logic [i2b_pkg::StepBits-1:0] cout;

  // Each step the digit is scaled by four and the incoming carry added.
  always_comb begin
    sum = {digit_q, {i2b_pkg::StepBits{1'b0}}} + i2b_pkg::CellSumW'(link_i.carry);
    if (sum >= i2b_pkg::Radix3) begin
      cout = 2'd3;
      rem  = sum - i2b_pkg::Radix3;
    end else if (sum >= i2b_pkg::Radix2) begin
      cout = 2'd2;
      rem  = sum - i2b_pkg::Radix2;
    end else if (sum >= i2b_pkg::Radix) begin
      cout = 2'd1;
      rem  = sum - i2b_pkg::Radix;
    end else begin
      cout = 2'd0;
      rem  = sum;
    end
  end

  always_comb begin
    digit_d      = digit_q;
    link_d.vld   = 1'b0;
    link_d.carry = cout;
    if (clr_i) begin
      digit_d = '0;
    end else if (link_i.vld) begin
      digit_d    = rem[i2b_pkg::DigitW-1:0];
      link_d.vld = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
      link_q  <= '0;
    end else begin
      digit_q <= digit_d;
      link_q  <= link_d;
    end
  end

  assign link_o  = link_q;
  assign digit_o = digit_q;

endmodule

`default_nettype wire

FILE: sv/int64_to_base100_number.sv
// Top level of the signed 64-bit to base-100 NUMBER encoder.
// Depends on i2b_pkg and instantiates a chain of i2b_cell digit cells.
// A new integer is taken only in the idle state, after the last byte of the previous one has been
// issued; an encoding has 1 to 12 bytes.
// Conversion runs 32 two-bit steps through the ten-cell chain and its skew, then a scan, then the bytes.
// Reset is asynchronous and clears all control state; no clearing pass.
`default_nettype none

module int64_to_base100_number (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic signed [i2b_pkg::ValueW-1:0] value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [i2b_pkg::ByteW-1:0]         out_byte_o,
  output logic                              last_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_EXP  = 3'd3;
  localparam logic [2:0] S_DIG  = 3'd4;
  localparam logic [2:0] S_TERM = 3'd5;

  logic [2:0]                   state_q, state_d;
  logic [i2b_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [i2b_pkg::ValueW-1:0]   mag_q, mag_d;
  logic                         neg_q, neg_d;
  logic [i2b_pkg::IdxW-1:0]     hi_q, hi_d, lo_q, lo_d, idx_q, idx_d;
  logic                         nz_q, nz_d;
  logic                         out_valid_q, out_valid_d;
  logic [i2b_pkg::ByteW-1:0]    out_byte_q, out_byte_d;
  logic                         last_q, last_d;

  logic                         in_acc;
  logic                         out_free;
  logic [i2b_pkg::DigitW-1:0]   cur_digit;
  i2b_pkg::link_t               link_w [i2b_pkg::DigitsMax];
  logic [i2b_pkg::DigitW-1:0]   digit_w [i2b_pkg::DigitsMax];

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign link_w[0].vld   = (state_q == S_CONV) && (cnt_q < i2b_pkg::CntW'(i2b_pkg::Steps));
  assign link_w[0].carry = mag_q[i2b_pkg::ValueW-1 -: i2b_pkg::StepBits];

  for (genvar g = 0; g < i2b_pkg::DigitsMax; g++) begin : g_cell
    if (g == i2b_pkg::DigitsMax - 1) begin : g_end
      i2b_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .clr_i   (in_acc),
        .link_i  (link_w[g]),
        .link_o  (),
        .digit_o (digit_w[g])
      );
    end else begin : g_mid
      i2b_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .clr_i   (in_acc),
        .link_i  (link_w[g]),
        .link_o  (link_w[g+1]),
        .digit_o (digit_w[g])
      );
    end
  end

  assign cur_digit = digit_w[idx_q];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    nz_d        = nz_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    last_d      = last_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          neg_d   = value_i[i2b_pkg::ValueW-1];
          mag_d   = value_i[i2b_pkg::ValueW-1] ? (~value_i + 64'd1) : value_i;
          cnt_d   = '0;
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        mag_d = {mag_q[i2b_pkg::ValueW-i2b_pkg::StepBits-1:0], {i2b_pkg::StepBits{1'b0}}};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == i2b_pkg::CntW'(i2b_pkg::ConvLast)) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        nz_d = 1'b0;
        hi_d = '0;
        lo_d = '0;
        for (int i = 0; i < i2b_pkg::DigitsMax; i++) begin
          if (digit_w[i] != '0) begin
            hi_d = i2b_pkg::IdxW'(i);
            nz_d = 1'b1;
          end
        end
        for (int i = i2b_pkg::DigitsMax - 1; i >= 0; i--) begin
          if (digit_w[i] != '0) begin
            lo_d = i2b_pkg::IdxW'(i);
          end
        end
        state_d = S_EXP;
      end
      S_EXP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (!nz_q) begin
            out_byte_d = i2b_pkg::ZeroByte;
            last_d     = 1'b1;
            state_d    = S_IDLE;
          end else begin
            out_byte_d = i2b_pkg::ExpFlag | (i2b_pkg::ExpBias + i2b_pkg::ByteW'(hi_q));
            if (neg_q) begin
              out_byte_d = ~out_byte_d;
            end
            last_d  = 1'b0;
            idx_d   = hi_q;
            state_d = S_DIG;
          end
        end
      end
      S_DIG: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (neg_q) begin
            out_byte_d = i2b_pkg::NegDigitTop - i2b_pkg::ByteW'(cur_digit);
          end else begin
            out_byte_d = i2b_pkg::ByteW'(cur_digit) + 8'd1;
          end
          last_d = !neg_q && (idx_q == lo_q);
          if (idx_q == lo_q) begin
            state_d = neg_q ? S_TERM : S_IDLE;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      S_TERM: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = i2b_pkg::TermByte;
          last_d      = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    hi_q       <= hi_d;
    lo_q       <= lo_d;
    nz_q       <= nz_d;
    idx_q      <= idx_d;
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

FILE: sv/i2b_checker.sv
// Port-level checker for int64_to_base100_number, with its bind statement.
// Depends on i2b_pkg for the field widths.
`default_nettype none

module i2b_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic [i2b_pkg::ValueW-1:0]   value_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [i2b_pkg::ByteW-1:0]    out_byte_o,
  input wire logic                         last_o
);

  // A stalled result transaction keeps its byte and flag.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) && $stable(last_o))
    else $error("result changed while stalled");

  // The encoder is busy in the cycle after it takes an integer.
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("new integer accepted during conversion");

  // While idle, only the closing byte of an earlier number may be pending.
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && out_valid_o |-> last_o)
    else $error("idle with an unfinished encoding");

  // A pending byte that is not the last keeps the input side closed.
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input open in the middle of an encoding");

  // A waiting input transaction keeps its value until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(value_i))
    else $error("input transaction changed while waiting");

endmodule

bind int64_to_base100_number i2b_checker u_i2b_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .value_i     (value_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o),
  .last_o      (last_o)
);

`default_nettype wire
